[rtl/core/nkl_pkg.sv]
// Shared constants, entry type and ring addressing for the nearest-K list.
// Used by the top level, nkl_cost, the interfaces and the testbench; depends on nothing.
`default_nettype none

package nkl_pkg;

    // Sizing of the list and the visible window
    localparam int MAX_KEPT    = 32;
    localparam int WINDOW_ROWS = 80;

    localparam int IDX_W = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
    localparam int CNT_W = $clog2(MAX_KEPT + 1);
    localparam int ROW_W = $clog2(WINDOW_ROWS + 1);

    // Field widths fixed by the interface
    localparam int DIST_W   = 16;
    localparam int TAG_W    = 8;
    localparam int COST_W   = 15;
    localparam int TOP_W    = 15;
    localparam int ROWS_W   = 14;
    localparam int COLS_W   = 8;
    localparam int BUDGET_W = 16;
    localparam int SPENT_W  = BUDGET_W + 1;

    localparam logic [BUDGET_W-1:0] BUDGET_RESET = 16'd8192;

    // Item kinds
    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_FINISH = 1'b1;

    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic [TAG_W-1:0]  tag;
        logic [COST_W-1:0] cost;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // Logical list position to physical slot; the list lives in a ring from head
    function automatic logic [IDX_W-1:0] phys_addr(input logic [IDX_W-1:0] head,
                                                   input logic [IDX_W-1:0] lidx);
        logic [IDX_W:0] sum;
        sum = {1'b0, head} + {1'b0, lidx};
        if (sum >= (IDX_W + 1)'(MAX_KEPT))
            sum = sum - (IDX_W + 1)'(MAX_KEPT);
        return sum[IDX_W-1:0];
    endfunction

endpackage

`default_nettype wire

[rtl/core/nkl_if.sv]
// Valid/ready channel interfaces for sprite items in and kept entries out.
// Depend on nkl_pkg for field widths.
`default_nettype none

interface nkl_in_if;
    logic                           valid;
    logic                           ready;
    logic                           kind;
    logic [nkl_pkg::DIST_W-1:0]     distance;
    logic signed [nkl_pkg::TOP_W-1:0] top_row;
    logic [nkl_pkg::ROWS_W-1:0]     row_count;
    logic [nkl_pkg::COLS_W-1:0]     column_count;
    logic [nkl_pkg::TAG_W-1:0]      sprite_tag;
    logic                           has_exempt;
    logic [nkl_pkg::DIST_W-1:0]     exempt_distance;

    modport source (output valid, kind, distance, top_row, row_count, column_count,
                    sprite_tag, has_exempt, exempt_distance, input ready);
    modport sink (input valid, kind, distance, top_row, row_count, column_count,
                  sprite_tag, has_exempt, exempt_distance, output ready);
endinterface

interface nkl_out_if;
    logic                        valid;
    logic                        ready;
    logic [nkl_pkg::TAG_W-1:0]   out_tag;
    logic [nkl_pkg::DIST_W-1:0]  out_distance;
    logic [nkl_pkg::COST_W-1:0]  pixel_cost;
    logic                        last;
    logic                        none_kept;

    modport source (output valid, out_tag, out_distance, pixel_cost, last, none_kept,
                    input ready);
    modport sink (input valid, out_tag, out_distance, pixel_cost, last, none_kept,
                  output ready);
endinterface

`default_nettype wire

[rtl/core/nearest_k_list_with_pixel_budget.sv]
// Top level of the nearest-K sprite list with pixel budget; sequencer and list store.
// Depends on nkl_pkg, nkl_if, nkl_ram and nkl_cost.
// The input is not ready while an item is in progress. An insert on a full list first
// fetches the farthest entry and drops the item if it is no nearer, else evicts that
// entry; it then moves each nearer entry one slot along to open the new entry's slot.
// A finish scans for the exempt distance, walks the budget near to far, then emits the
// kept entries far to near, or one none_kept beat, waiting while the output stalls.
// The single read port of the list memory is used at most once per cycle and serves
// every step. The list is a ring in that memory, so evicting
// the farthest entry only moves the head pointer. Results leave through an output
// register, so the last result may wait while the next item is taken. No clearing pass
// is needed after reset.
`default_nettype none

module nearest_k_list_with_pixel_budget (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    nkl_in_if.sink                            in_item,
    nkl_out_if.source                         out_item,
    input  wire logic                         cfg_we,
    input  wire logic [nkl_pkg::BUDGET_W-1:0] cfg_wdata
);
    import nkl_pkg::*;

    // Sequencer codes
    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_FULLCMP   = 4'd1;
    localparam logic [3:0] S_INS_START = 4'd2;
    localparam logic [3:0] S_INS_CMP   = 4'd3;
    localparam logic [3:0] S_SCAN      = 4'd4;
    localparam logic [3:0] S_BUDGET    = 4'd5;
    localparam logic [3:0] S_EMIT_RD   = 4'd6;
    localparam logic [3:0] S_EMIT_LD   = 4'd7;
    localparam logic [3:0] S_NONE      = 4'd8;

    localparam logic [CNT_W-1:0] FULL = CNT_W'(MAX_KEPT);

    logic [3:0]          state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [IDX_W-1:0]    head_reg, head_next;
    logic [CNT_W-1:0]    idx_reg, idx_next;
    logic [BUDGET_W-1:0] budget_reg;
    logic [SPENT_W-1:0]  spent_reg, spent_next;
    logic                pend_reg, pend_next;
    logic [IDX_W-1:0]    pend_idx_reg, pend_idx_next;
    logic                found_reg, found_next;
    logic                taken_reg, taken_next;
    logic                exhausted_reg, exhausted_next;
    logic                any_kept_reg, any_kept_next;
    logic [IDX_W-1:0]    last_idx_reg, last_idx_next;
    logic [MAX_KEPT-1:0] keep_reg, keep_next;
    logic                out_valid_reg, out_valid_next;

    // Item payload held for the run
    logic [DIST_W-1:0]   dist_reg, dist_next;
    logic [TAG_W-1:0]    tag_reg, tag_next;
    logic                has_exempt_reg, has_exempt_next;
    logic [DIST_W-1:0]   exempt_dist_reg, exempt_dist_next;
    logic [DIST_W-1:0]   near_dist_reg, near_dist_next;

    // Output register payload
    logic [TAG_W-1:0]    out_tag_reg, out_tag_next;
    logic [DIST_W-1:0]   out_dist_reg, out_dist_next;
    logic [COST_W-1:0]   out_cost_reg, out_cost_next;
    logic                out_last_reg, out_last_next;
    logic                out_none_reg, out_none_next;

    logic                accept;
    logic                out_free;
    logic                rd_en;
    logic [IDX_W-1:0]    rd_lidx;
    logic                wr_en;
    logic [IDX_W-1:0]    wr_lidx;
    entry_t              wr_entry;
    logic [ENTRY_W-1:0]  rd_data;
    entry_t              rd_entry;
    logic [COST_W-1:0]   new_cost;
    entry_t              new_entry;
    logic [CNT_W-1:0]    idx_dec;
    logic [CNT_W-1:0]    idx_dec2;
    logic [SPENT_W-1:0]  spent_sum;
    logic                over_budget;

    assign accept       = in_item.valid && in_item.ready;
    assign in_item.ready = (state_reg == S_IDLE);
    assign out_free     = !out_valid_reg || out_item.ready;

    assign rd_entry  = entry_t'(rd_data);
    assign new_entry = '{distance: dist_reg, tag: tag_reg, cost: new_cost};
    assign idx_dec   = idx_reg - CNT_W'(1);
    assign idx_dec2  = idx_reg - CNT_W'(2);

    // Shared add and compare of the budget walk
    assign spent_sum   = spent_reg + SPENT_W'(rd_entry.cost);
    assign over_budget = spent_sum > SPENT_W'(budget_reg);

    nkl_cost u_cost (
        .clk          (clk),
        .load         (accept),
        .top_row      (in_item.top_row),
        .row_count    (in_item.row_count),
        .column_count (in_item.column_count),
        .cost         (new_cost)
    );

    nkl_ram #(
        .DEPTH (MAX_KEPT),
        .WIDTH (ENTRY_W)
    ) u_list (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (phys_addr(head_reg, wr_lidx)),
        .wr_data (wr_entry),
        .rd_en   (rd_en),
        .rd_addr (phys_addr(head_reg, rd_lidx)),
        .rd_data (rd_data)
    );

    // Sequencer
    always_comb
    begin
        state_next       = state_reg;
        count_next       = count_reg;
        head_next        = head_reg;
        idx_next         = idx_reg;
        spent_next       = spent_reg;
        pend_next        = pend_reg;
        pend_idx_next    = pend_idx_reg;
        found_next       = found_reg;
        taken_next       = taken_reg;
        exhausted_next   = exhausted_reg;
        any_kept_next    = any_kept_reg;
        last_idx_next    = last_idx_reg;
        keep_next        = keep_reg;
        dist_next        = dist_reg;
        tag_next         = tag_reg;
        has_exempt_next  = has_exempt_reg;
        exempt_dist_next = exempt_dist_reg;
        near_dist_next   = near_dist_reg;
        out_valid_next   = out_valid_reg && !out_item.ready;
        out_tag_next     = out_tag_reg;
        out_dist_next    = out_dist_reg;
        out_cost_next    = out_cost_reg;
        out_last_next    = out_last_reg;
        out_none_next    = out_none_reg;
        rd_en            = 1'b0;
        rd_lidx          = '0;
        wr_en            = 1'b0;
        wr_lidx          = '0;
        wr_entry         = new_entry;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    dist_next        = in_item.distance;
                    tag_next         = in_item.sprite_tag;
                    has_exempt_next  = in_item.has_exempt;
                    exempt_dist_next = in_item.exempt_distance;
                    idx_next         = count_reg;
                    pend_next        = 1'b0;
                    if (in_item.kind == KIND_INSERT)
                    begin
                        if (count_reg == FULL)
                        begin
                            // Fetch the farthest entry to test for eviction
                            rd_en      = 1'b1;
                            rd_lidx    = '0;
                            state_next = S_FULLCMP;
                        end
                        else
                            state_next = S_INS_START;
                    end
                    else if (count_reg == '0)
                        state_next = S_NONE;
                    else
                    begin
                        idx_next   = '0;
                        found_next = 1'b0;
                        state_next = S_SCAN;
                    end
                end
            end

            S_FULLCMP:
            begin
                if (dist_reg >= rd_entry.distance)
                    state_next = S_IDLE;
                else
                begin
                    head_next  = phys_addr(head_reg, IDX_W'(1));
                    count_next = FULL - CNT_W'(1);
                    idx_next   = FULL - CNT_W'(1);
                    state_next = S_INS_START;
                end
            end

            S_INS_START:
            begin
                if (idx_reg == '0)
                begin
                    wr_en      = 1'b1;
                    wr_lidx    = '0;
                    count_next = count_reg + CNT_W'(1);
                    state_next = S_IDLE;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_lidx    = idx_dec[IDX_W-1:0];
                    state_next = S_INS_CMP;
                end
            end

            S_INS_CMP:
            begin
                // Entry at idx-1 is in rd_entry; nearer ones move down one slot
                wr_en   = 1'b1;
                wr_lidx = idx_reg[IDX_W-1:0];
                if (rd_entry.distance < dist_reg)
                begin
                    wr_entry = rd_entry;
                    idx_next = idx_dec;
                    if (idx_dec == '0)
                        state_next = S_INS_START;
                    else
                    begin
                        rd_en   = 1'b1;
                        rd_lidx = idx_dec2[IDX_W-1:0];
                    end
                end
                else
                begin
                    count_next = count_reg + CNT_W'(1);
                    state_next = S_IDLE;
                end
            end

            S_SCAN:
            begin
                // Look for the exempt distance, one read per cycle
                if (idx_reg != count_reg)
                begin
                    rd_en     = 1'b1;
                    rd_lidx   = idx_reg[IDX_W-1:0];
                    idx_next  = idx_reg + CNT_W'(1);
                    pend_next = 1'b1;
                end
                else
                    pend_next = 1'b0;
                if (pend_reg)
                begin
                    near_dist_next = rd_entry.distance;
                    if (rd_entry.distance == exempt_dist_reg)
                        found_next = 1'b1;
                end
                else if (idx_reg == count_reg)
                begin
                    if (!found_reg)
                        exempt_dist_next = near_dist_reg;
                    idx_next       = count_reg;
                    spent_next     = '0;
                    taken_next     = 1'b0;
                    exhausted_next = 1'b0;
                    any_kept_next  = 1'b0;
                    keep_next      = '0;
                    state_next     = S_BUDGET;
                end
            end

            S_BUDGET:
            begin
                // Walk near to far, one read per cycle
                if (idx_reg != '0)
                begin
                    rd_en         = 1'b1;
                    rd_lidx       = idx_dec[IDX_W-1:0];
                    idx_next      = idx_dec;
                    pend_next     = 1'b1;
                    pend_idx_next = idx_dec[IDX_W-1:0];
                end
                else
                    pend_next = 1'b0;
                if (pend_reg)
                begin
                    if (has_exempt_reg && !taken_reg
                        && rd_entry.distance == exempt_dist_reg)
                    begin
                        taken_next              = 1'b1;
                        keep_next[pend_idx_reg] = 1'b1;
                        if (!any_kept_reg)
                        begin
                            any_kept_next = 1'b1;
                            last_idx_next = pend_idx_reg;
                        end
                    end
                    else if (exhausted_reg || over_budget)
                        exhausted_next = 1'b1;
                    else
                    begin
                        spent_next              = spent_sum;
                        keep_next[pend_idx_reg] = 1'b1;
                        if (!any_kept_reg)
                        begin
                            any_kept_next = 1'b1;
                            last_idx_next = pend_idx_reg;
                        end
                    end
                end
                else if (idx_reg == '0)
                begin
                    state_next = any_kept_reg ? S_EMIT_RD : S_NONE;
                end
            end

            S_EMIT_RD:
            begin
                if (idx_reg == count_reg)
                begin
                    count_next = '0;
                    state_next = S_IDLE;
                end
                else if (keep_reg[idx_reg[IDX_W-1:0]])
                begin
                    rd_en      = 1'b1;
                    rd_lidx    = idx_reg[IDX_W-1:0];
                    state_next = S_EMIT_LD;
                end
                else
                    idx_next = idx_reg + CNT_W'(1);
            end

            S_EMIT_LD:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_tag_next   = rd_entry.tag;
                    out_dist_next  = rd_entry.distance;
                    out_cost_next  = rd_entry.cost;
                    out_none_next  = 1'b0;
                    out_last_next  = (idx_reg[IDX_W-1:0] == last_idx_reg);
                    idx_next       = idx_reg + CNT_W'(1);
                    if (idx_reg[IDX_W-1:0] == last_idx_reg)
                    begin
                        count_next = '0;
                        state_next = S_IDLE;
                    end
                    else
                        state_next = S_EMIT_RD;
                end
            end

            S_NONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_tag_next   = '0;
                    out_dist_next  = '0;
                    out_cost_next  = '0;
                    out_last_next  = 1'b0;
                    out_none_next  = 1'b1;
                    count_next     = '0;
                    state_next     = S_IDLE;
                end
            end

            default:
                state_next = S_IDLE;
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            head_reg      <= '0;
            idx_reg       <= '0;
            budget_reg    <= BUDGET_RESET;
            spent_reg     <= '0;
            pend_reg      <= 1'b0;
            pend_idx_reg  <= '0;
            found_reg     <= 1'b0;
            taken_reg     <= 1'b0;
            exhausted_reg <= 1'b0;
            any_kept_reg  <= 1'b0;
            last_idx_reg  <= '0;
            keep_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            head_reg      <= head_next;
            idx_reg       <= idx_next;
            spent_reg     <= spent_next;
            pend_reg      <= pend_next;
            pend_idx_reg  <= pend_idx_next;
            found_reg     <= found_next;
            taken_reg     <= taken_next;
            exhausted_reg <= exhausted_next;
            any_kept_reg  <= any_kept_next;
            last_idx_reg  <= last_idx_next;
            keep_reg      <= keep_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
                budget_reg <= cfg_wdata;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        dist_reg        <= dist_next;
        tag_reg         <= tag_next;
        has_exempt_reg  <= has_exempt_next;
        exempt_dist_reg <= exempt_dist_next;
        near_dist_reg   <= near_dist_next;
        out_tag_reg     <= out_tag_next;
        out_dist_reg    <= out_dist_next;
        out_cost_reg    <= out_cost_next;
        out_last_reg    <= out_last_next;
        out_none_reg    <= out_none_next;
    end

    assign out_item.valid        = out_valid_reg;
    assign out_item.out_tag      = out_tag_reg;
    assign out_item.out_distance = out_dist_reg;
    assign out_item.pixel_cost   = out_cost_reg;
    assign out_item.last         = out_last_reg;
    assign out_item.none_kept    = out_none_reg;

    // Checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL)
        else $error("list count above capacity");

    a_ins_room: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_INS_START |-> count_reg < FULL)
        else $error("insert started on a full list");

    a_spent_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_BUDGET |-> spent_reg <= SPENT_W'(budget_reg))
        else $error("admitted cost exceeds pixel budget");

    a_none_beat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_none_reg |-> !out_last_reg && out_tag_reg == '0
            && out_dist_reg == '0 && out_cost_reg == '0)
        else $error("empty-frame beat carries data");

endmodule

`default_nettype wire

[rtl/core/nkl_ram.sv]
// Generic single-write, single-read memory with registered read data.
// Self-contained; no package dependency.
`default_nettype none

module nkl_ram #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 39,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
    end

    // Read port, data held until the next read
    always_ff @(posedge clk)
    begin
        if (rd_en)
            rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

[rtl/core/nkl_cost.sv]
// Clipped pixel cost of one sprite rectangle, registered on load.
// Depends on nkl_pkg for the window height and field widths.
`default_nettype none

module nkl_cost (
    input  wire logic                                clk,
    input  wire logic                                load,
    input  wire logic signed [nkl_pkg::TOP_W-1:0]    top_row,
    input  wire logic [nkl_pkg::ROWS_W-1:0]          row_count,
    input  wire logic [nkl_pkg::COLS_W-1:0]          column_count,
    output logic [nkl_pkg::COST_W-1:0]               cost
);
    import nkl_pkg::*;

    localparam int SUM_W  = TOP_W + 2;
    localparam int PROD_W = COLS_W + ROW_W;
    localparam logic signed [SUM_W-1:0] WIN_S = SUM_W'(WINDOW_ROWS);

    logic signed [SUM_W-1:0] top_s;
    logic signed [SUM_W-1:0] bot_s;
    logic signed [SUM_W-1:0] top_c;
    logic signed [SUM_W-1:0] bot_c;
    logic signed [SUM_W-1:0] span;
    logic [ROW_W-1:0]        rows_c;
    logic [PROD_W-1:0]       prod;

    // Clip the row span to the window
    always_comb
    begin
        top_s = {{(SUM_W - TOP_W){top_row[TOP_W-1]}}, top_row};
        bot_s = top_s + signed'({{(SUM_W - ROWS_W){1'b0}}, row_count});
        top_c = top_s[SUM_W-1] ? '0 : top_s;
        bot_c = (bot_s > WIN_S) ? WIN_S : bot_s;
        span  = bot_c - top_c;
        rows_c = (bot_c <= top_c) ? '0 : span[ROW_W-1:0];
        prod   = PROD_W'(column_count) * PROD_W'(rows_c);
    end

    always_ff @(posedge clk)
    begin
        if (load)
            cost <= COST_W'(prod);
    end

endmodule

`default_nettype wire

[test/tb_top.sv]
// Self-checking testbench for the nearest-K sprite list with pixel budget.
// Depends on nkl_pkg, the nkl_in_if/nkl_out_if interfaces and the top-level RTL.
// A local predictor mirrors the sorted list and the budget pass; each result beat is checked.

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import nkl_pkg::*;

    // Time for the block to finish an insert or the tail of a finish run
    localparam int SETTLE_CYCLES = 2 * MAX_KEPT + 40;
    localparam int PHASE_ITEMS   = 110;

    typedef struct {
        logic                    kind;
        logic [DIST_W-1:0]       distance;
        logic signed [TOP_W-1:0] top_row;
        logic [ROWS_W-1:0]       row_count;
        logic [COLS_W-1:0]       column_count;
        logic [TAG_W-1:0]        sprite_tag;
        logic                    has_exempt;
        logic [DIST_W-1:0]       exempt_distance;
    } sprite_item_t;

    typedef struct {
        logic [TAG_W-1:0]  tag;
        logic [DIST_W-1:0] distance;
        logic [COST_W-1:0] cost;
        logic              last;
        logic              none_kept;
    } kept_beat_t;

    logic                clk;
    logic                rst_n;
    logic                cfg_we;
    logic [BUDGET_W-1:0] cfg_wdata;

    nkl_in_if  in_bus ();
    nkl_out_if out_bus ();

    nearest_k_list_with_pixel_budget u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_item   (in_bus),
        .out_item  (out_bus),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // Predictor state: sprite_list[0] is the farthest entry
    entry_t              sprite_list[$];
    logic [BUDGET_W-1:0] budget_now = BUDGET_RESET;
    kept_beat_t          beats_due[$];

    int errors      = 0;
    int items_sent  = 0;
    int frames_done = 0;
    int beats_seen  = 0;
    bit no_idle     = 1'b0;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Run limit
    initial
    begin
        #60_000_000;
        $display("tb_top: errors");
        $finish;
    end

    // Gap length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Pixel cost of a rectangle with its rows clipped to the window
    function automatic logic [COST_W-1:0] sprite_cost(logic signed [TOP_W-1:0] top,
                                                      logic [ROWS_W-1:0] rows,
                                                      logic [COLS_W-1:0] cols);
        int          row_lo;
        int          end_row;
        int unsigned area;
        row_lo  = int'(top);
        end_row = row_lo + int'(rows);
        if (row_lo < 0)
            row_lo = 0;
        if (end_row > WINDOW_ROWS)
            end_row = WINDOW_ROWS;
        if (end_row <= row_lo)
            return '0;
        area = int'(cols) * (end_row - row_lo);
        return COST_W'(area);
    endfunction

    // Sorted insert, far to near; ties go nearer; full list evicts farthest
    function automatic void list_insert(entry_t e);
        int pos;
        if (sprite_list.size() >= MAX_KEPT)
        begin
            if (e.distance >= sprite_list[0].distance)
                return;
            void'(sprite_list.pop_front());
        end
        pos = sprite_list.size();
        while (pos > 0 && sprite_list[pos-1].distance < e.distance)
            pos--;
        sprite_list.insert(pos, e);
    endfunction

    // Exempt pick, greedy budget walk near to far, then queue kept beats far to near
    function automatic void apply_budget(logic has_ex, logic [DIST_W-1:0] ex_dist);
        bit                keep[MAX_KEPT];
        int                n;
        int                k;
        bit                found;
        bit                exempt_done;
        bit                exhausted;
        int unsigned       spent;
        int                emitted;
        kept_beat_t        b;
        logic [DIST_W-1:0] target;
        n      = sprite_list.size();
        target = ex_dist;
        if (n > 0 && has_ex)
        begin
            found = 1'b0;
            for (k = 0; k < n; k++)
                if (sprite_list[k].distance == ex_dist)
                    found = 1'b1;
            if (!found)
                target = sprite_list[n-1].distance;
        end
        spent       = 0;
        exempt_done = 1'b0;
        exhausted   = 1'b0;
        for (k = n - 1; k >= 0; k--)
        begin
            if (has_ex && !exempt_done && sprite_list[k].distance == target)
            begin
                exempt_done = 1'b1;
                keep[k]     = 1'b1;
            end
            else if (exhausted || spent + sprite_list[k].cost > budget_now)
            begin
                exhausted = 1'b1;
                keep[k]   = 1'b0;
            end
            else
            begin
                spent   += sprite_list[k].cost;
                keep[k] = 1'b1;
            end
        end
        emitted = 0;
        for (k = 0; k < n; k++)
        begin
            if (keep[k])
            begin
                b.tag       = sprite_list[k].tag;
                b.distance  = sprite_list[k].distance;
                b.cost      = sprite_list[k].cost;
                b.last      = 1'b0;
                b.none_kept = 1'b0;
                beats_due.push_back(b);
                emitted++;
            end
        end
        if (emitted == 0)
        begin
            b.tag       = '0;
            b.distance  = '0;
            b.cost      = '0;
            b.last      = 1'b0;
            b.none_kept = 1'b1;
            beats_due.push_back(b);
        end
        else
            beats_due[beats_due.size()-1].last = 1'b1;
        sprite_list.delete();
    endfunction

    // Output ready with random stalls
    initial
    begin
        int stall;
        stall         = 0;
        out_bus.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall > 0)
            begin
                out_bus.ready <= 1'b0;
                stall--;
            end
            else
            begin
                out_bus.ready <= 1'b1;
                if (!no_idle && $urandom_range(0, 3) == 0)
                    stall = pick_gap();
            end
        end
    end

    // Watch config writes, accepted items and result beats at each edge
    always @(posedge clk)
    begin : watch_beats
        entry_t     e;
        kept_beat_t want;
        if (rst_n)
        begin
            if (cfg_we)
                budget_now = cfg_wdata;
            if (in_bus.valid && in_bus.ready)
            begin
                items_sent++;
                if (in_bus.kind == KIND_INSERT)
                begin
                    e.distance = in_bus.distance;
                    e.tag      = in_bus.sprite_tag;
                    e.cost     = sprite_cost(in_bus.top_row, in_bus.row_count,
                                             in_bus.column_count);
                    list_insert(e);
                end
                else
                begin
                    apply_budget(in_bus.has_exempt, in_bus.exempt_distance);
                    frames_done++;
                end
            end
            if (out_bus.valid && out_bus.ready)
            begin
                beats_seen++;
                if (beats_due.size() == 0)
                begin
                    $error("unexpected result beat: tag %0d distance %0d",
                           out_bus.out_tag, out_bus.out_distance);
                    errors++;
                end
                else
                begin
                    want = beats_due.pop_front();
                    if (out_bus.out_tag !== want.tag)
                    begin
                        $error("out_tag: expected %0d, got %0d", want.tag, out_bus.out_tag);
                        errors++;
                    end
                    if (out_bus.out_distance !== want.distance)
                    begin
                        $error("out_distance: expected %0d, got %0d",
                               want.distance, out_bus.out_distance);
                        errors++;
                    end
                    if (out_bus.pixel_cost !== want.cost)
                    begin
                        $error("pixel_cost: expected %0d, got %0d",
                               want.cost, out_bus.pixel_cost);
                        errors++;
                    end
                    if (out_bus.last !== want.last)
                    begin
                        $error("last: expected %0d, got %0d", want.last, out_bus.last);
                        errors++;
                    end
                    if (out_bus.none_kept !== want.none_kept)
                    begin
                        $error("none_kept: expected %0d, got %0d",
                               want.none_kept, out_bus.none_kept);
                        errors++;
                    end
                end
            end
        end
    end

    // Drive one item beat and wait until it is taken; valid stays high afterward
    task automatic send_beat(sprite_item_t it);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_bus.valid           <= 1'b1;
        in_bus.kind            <= it.kind;
        in_bus.distance        <= it.distance;
        in_bus.top_row         <= it.top_row;
        in_bus.row_count       <= it.row_count;
        in_bus.column_count    <= it.column_count;
        in_bus.sprite_tag      <= it.sprite_tag;
        in_bus.has_exempt      <= it.has_exempt;
        in_bus.exempt_distance <= it.exempt_distance;
        do
            @(posedge clk);
        while (in_bus.ready !== 1'b1);
    endtask

    task automatic send_insert(logic [DIST_W-1:0] dist_in, logic signed [TOP_W-1:0] top,
                               logic [ROWS_W-1:0] rows, logic [COLS_W-1:0] cols,
                               logic [TAG_W-1:0] tag);
        sprite_item_t it;
        it.kind            = KIND_INSERT;
        it.distance        = dist_in;
        it.top_row         = top;
        it.row_count       = rows;
        it.column_count    = cols;
        it.sprite_tag      = tag;
        it.has_exempt      = 1'($urandom_range(0, 1));
        it.exempt_distance = DIST_W'($urandom);
        send_beat(it);
    endtask

    // Finish beat; the sprite fields are don't-care and get random values
    task automatic send_finish(logic has_ex, logic [DIST_W-1:0] ex_dist);
        sprite_item_t it;
        it.kind            = KIND_FINISH;
        it.distance        = DIST_W'($urandom);
        it.top_row         = TOP_W'($urandom);
        it.row_count       = ROWS_W'($urandom);
        it.column_count    = COLS_W'($urandom);
        it.sprite_tag      = TAG_W'($urandom);
        it.has_exempt      = has_ex;
        it.exempt_distance = ex_dist;
        send_beat(it);
    endtask

    // Hold the sender until every expected beat is in and the block has settled
    task automatic wait_idle();
        in_bus.valid <= 1'b0;
        @(posedge clk);
        while (beats_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_budget(logic [BUDGET_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    // Finish on an empty list, with and without an exempt request
    task automatic test_empty_frame();
        send_finish(1'b1, 16'hFFFF);
        send_finish(1'b0, 16'h0000);
    endtask

    // Field extremes, row clipping on both ends, equal distances, exempt match
    task automatic test_clipping_and_ties();
        send_insert(16'hFFFF, -15'sd16384, 14'd16383, 8'd255, 8'd255);
        send_insert(16'h0000, 15'sd16383, 14'd16383, 8'd255, 8'd0);
        send_insert(16'd100, -15'sd10, 14'd50, 8'd255, 8'd1);
        send_insert(16'd100, 15'sd0, 14'd80, 8'd255, 8'd2);
        send_insert(16'd100, 15'sd70, 14'd20, 8'd3, 8'd3);
        send_insert(16'd50, 15'sd10, 14'd0, 8'd200, 8'd4);
        send_insert(16'd200, -15'sd5, 14'd100, 8'd100, 8'd5);
        send_finish(1'b1, 16'd100);
    endtask

    // Exempt distance with no match falls back to the nearest; exempt flag off
    task automatic test_exempt_fallback();
        send_insert(16'd300, 15'sd0, 14'd40, 8'd50, 8'd10);
        send_insert(16'd10, 15'sd20, 14'd30, 8'd60, 8'd11);
        send_insert(16'd10, 15'sd5, 14'd10, 8'd70, 8'd12);
        send_insert(16'd700, 15'sd60, 14'd30, 8'd90, 8'd13);
        send_finish(1'b1, 16'd12345);
        send_insert(16'd10, 15'sd0, 14'd80, 8'd120, 8'd14);
        send_insert(16'd20, 15'sd0, 14'd80, 8'd120, 8'd15);
        send_finish(1'b0, 16'd10);
    endtask

    // Budget of zero keeps nothing; largest budget keeps everything
    task automatic test_budget_extremes();
        wait_idle();
        write_budget(16'h0000);
        send_insert(16'd5, 15'sd0, 14'd10, 8'd10, 8'd20);
        send_insert(16'd6, 15'sd0, 14'd20, 8'd10, 8'd21);
        send_finish(1'b0, 16'd5);
        wait_idle();
        write_budget(16'hFFFF);
        send_insert(16'd1000, 15'sd0, 14'd80, 8'd255, 8'd30);
        send_insert(16'd900, -15'sd20, 14'd200, 8'd255, 8'd31);
        send_insert(16'd800, 15'sd0, 14'd16383, 8'd255, 8'd32);
        send_finish(1'b1, 16'd900);
    endtask

    // Random frames: mostly short lists, some filling past capacity
    task automatic test_random_frames(int item_goal);
        int                sent;
        int                frame_len;
        int                r;
        bit                narrow;
        logic [DIST_W-1:0] base;
        logic [DIST_W-1:0] sprite_dist;
        logic [DIST_W-1:0] ex_dist;
        logic [DIST_W-1:0] frame_dists[$];
        logic signed [TOP_W-1:0] top;
        logic [ROWS_W-1:0] rows;
        sent = 0;
        while (sent < item_goal)
        begin
            r = $urandom_range(0, 99);
            if (r < 70)
                frame_len = $urandom_range(0, 10);
            else if (r < 90)
                frame_len = $urandom_range(11, MAX_KEPT - 1);
            else
                frame_len = $urandom_range(MAX_KEPT, MAX_KEPT + 13);
            narrow = 1'($urandom_range(0, 1));
            base   = DIST_W'($urandom);
            frame_dists.delete();
            repeat (frame_len)
            begin
                sprite_dist = narrow ? base + DIST_W'($urandom_range(0, 7))
                                     : DIST_W'($urandom);
                if ($urandom_range(0, 3) != 0)
                    top = TOP_W'(int'($urandom_range(0, 130)) - 40);
                else
                    top = TOP_W'($urandom);
                if ($urandom_range(0, 3) != 0)
                    rows = ROWS_W'($urandom_range(0, 100));
                else
                    rows = ROWS_W'($urandom);
                frame_dists.push_back(sprite_dist);
                send_insert(sprite_dist, top, rows, COLS_W'($urandom), TAG_W'($urandom));
                sent++;
            end
            if (frame_dists.size() > 0 && $urandom_range(0, 2) != 0)
                ex_dist = frame_dists[$urandom_range(0, frame_dists.size() - 1)];
            else
                ex_dist = DIST_W'($urandom);
            send_finish($urandom_range(0, 3) != 0, ex_dist);
            sent++;
            // now and then let the output side drain completely
            if ($urandom_range(0, 15) == 0)
                wait_idle();
        end
    endtask

    // Test sequence
    initial
    begin : run_tests
        in_bus.valid           = 1'b0;
        in_bus.kind            = KIND_INSERT;
        in_bus.distance        = '0;
        in_bus.top_row         = '0;
        in_bus.row_count       = '0;
        in_bus.column_count    = '0;
        in_bus.sprite_tag      = '0;
        in_bus.has_exempt      = 1'b0;
        in_bus.exempt_distance = '0;
        cfg_we                 = 1'b0;
        cfg_wdata              = '0;
        rst_n                  = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_frame();
        test_clipping_and_ties();
        test_exempt_fallback();
        test_budget_extremes();

        wait_idle();
        write_budget(16'($urandom_range(0, 3000)));
        test_random_frames(PHASE_ITEMS);

        // back-to-back stretch with the widest budget
        wait_idle();
        write_budget(16'hFFFF);
        no_idle = 1'b1;
        test_random_frames(PHASE_ITEMS);
        no_idle = 1'b0;

        wait_idle();
        write_budget(16'h0000);
        test_random_frames(PHASE_ITEMS);

        wait_idle();
        write_budget(16'($urandom));
        test_random_frames(PHASE_ITEMS);

        wait_idle();
        $display("summary: %0d items, %0d frames, %0d result beats checked, %0d errors",
                 items_sent, frames_done, beats_seen, errors);
        $display("summary: budgets 0, reset, max and random; full-list eviction, ties, exempt");
        if (errors == 0 && beats_due.size() == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule
